// ===== design/iol_pkg.sv =====
// iol_pkg: opcodes, status codes and cell control types for the ordered list core.
// No dependencies. Used by iol_cell and indexed_ordered_list_core.
package iol_pkg;

  // Position and count width that covers the largest supported capacity (1024).
  localparam int POS_W = 11;

  typedef enum logic [3:0] {
    OP_PUSH_BACK  = 4'd0,
    OP_PUSH_FRONT = 4'd1,
    OP_INSERT_AT  = 4'd2,
    OP_POP_FRONT  = 4'd3,
    OP_POP_BACK   = 4'd4,
    OP_REMOVE_AT  = 4'd5,
    OP_READ_AT    = 4'd6,
    OP_READ_FIRST = 4'd7,
    OP_READ_LAST  = 4'd8,
    OP_WRITE_AT   = 4'd9
  } op_t;

  typedef enum logic [1:0] {
    ST_OK    = 2'd0,
    ST_RANGE = 2'd1,
    ST_EMPTY = 2'd2,
    ST_FULL  = 2'd3
  } status_t;

  typedef enum logic [1:0] {
    CELL_HOLD   = 2'd0,
    CELL_INSERT = 2'd1,
    CELL_REMOVE = 2'd2,
    CELL_WRITE  = 2'd3
  } cell_op_t;

  typedef struct packed {
    cell_op_t          kind;
    logic [POS_W-1:0]  pos;
  } cell_ctl_t;

endpackage

// ===== design/iol_cell.sv =====
// iol_cell: one list slot; shifts with its neighbors on insert and remove.
// Depends on iol_pkg (cell_ctl_t, cell_op_t, POS_W).
module iol_cell #(
  parameter int IDX       = 0,
  parameter int WORD_BITS = 32
) (
  input  logic                  clk,
  input  iol_pkg::cell_ctl_t    ctl,
  input  logic [WORD_BITS-1:0]  din,
  input  logic [WORD_BITS-1:0]  prev_word,
  input  logic [WORD_BITS-1:0]  next_word,
  output logic [WORD_BITS-1:0]  word,
  output logic [WORD_BITS-1:0]  tap
);

  localparam logic [iol_pkg::POS_W-1:0] MY_POS = iol_pkg::POS_W'(IDX);

  logic at_pos;
  logic past_pos;

  assign at_pos   = (ctl.pos == MY_POS);
  assign past_pos = (MY_POS > ctl.pos);
  assign tap      = at_pos ? word : '0;

  always_ff @(posedge clk) begin
    case (ctl.kind)
      iol_pkg::CELL_INSERT: begin
        if (past_pos) begin
          word <= prev_word;
        end else if (at_pos) begin
          word <= din;
        end
      end
      iol_pkg::CELL_REMOVE: begin
        if (past_pos || at_pos) begin
          word <= next_word;
        end
      end
      iol_pkg::CELL_WRITE: begin
        if (at_pos) begin
          word <= din;
        end
      end
      default: begin
      end
    endcase
  end

endmodule

// ===== design/indexed_ordered_list_core.sv =====
// indexed_ordered_list_core: bounded ordered list / deque built from a row of shifting cells.
// Depends on iol_pkg and iol_cell.
//
//  channel  | dir | tdata fields (low bit up)              | tuser
//  s_axis   | in  | opcode[3:0] position[10:4] data_in[42:11] | -
//  m_axis   | out | data_out[31:0] status[33:32] count[40:34] is_empty[41] | -
//
// Each request is first registered in the request stage; then the cell row shifts,
// overwrites or reads and the result register loads. The next request is taken
// while a result waits; a stalled result holds the request stage.
// Reset clears the count and the handshake state; cell contents are left as they are.
module indexed_ordered_list_core #(
  parameter int CAPACITY  = 64,
  parameter int WORD_BITS = 32
) (
  input  logic        clk,
  input  logic        rst,
  input  logic        s_axis_tvalid,
  output logic        s_axis_tready,
  input  logic [47:0] s_axis_tdata,   // opcode, position, data_in, zero pad
  output logic        m_axis_tvalid,
  input  logic        m_axis_tready,
  output logic [47:0] m_axis_tdata    // data_out, status, count, is_empty, zero pad
);

  localparam int CNT_W = $clog2(CAPACITY + 1);
  localparam logic [CNT_W-1:0] CAP_CNT = CNT_W'(CAPACITY);

  // request stage
  logic                 cmd_valid;
  logic [3:0]           cmd_op;
  logic [6:0]           cmd_pos;
  logic [31:0]          cmd_data;

  logic [CNT_W-1:0]     count;
  logic [CNT_W-1:0]     count_next;

  // result register
  logic                 out_valid;
  logic [31:0]          out_data;
  iol_pkg::status_t     out_status;
  logic [6:0]           out_count;
  logic                 out_empty;

  logic                 exec;
  logic                 in_fire;

  iol_pkg::cell_ctl_t   ctl;
  iol_pkg::cell_op_t    kind;
  logic [iol_pkg::POS_W-1:0] op_pos;
  iol_pkg::status_t     status;
  logic                 rd;

  logic [WORD_BITS-1:0] word_in;
  logic [WORD_BITS-1:0] words [CAPACITY];
  logic [WORD_BITS-1:0] taps  [CAPACITY];
  logic [WORD_BITS-1:0] tap_or;
  logic [31:0]          rd_word;

  logic [iol_pkg::POS_W-1:0] pos_w;
  logic [iol_pkg::POS_W-1:0] cnt_w;
  logic                 full;
  logic                 empty;

  assign in_fire       = s_axis_tvalid && s_axis_tready;
  assign s_axis_tready = !cmd_valid;
  assign exec          = cmd_valid && (!out_valid || m_axis_tready);

  assign pos_w = iol_pkg::POS_W'(cmd_pos);
  assign cnt_w = iol_pkg::POS_W'(count);
  assign full  = (count == CAP_CNT);
  assign empty = (count == '0);

  always_comb begin
    kind       = iol_pkg::CELL_HOLD;
    op_pos     = pos_w;
    status     = iol_pkg::ST_OK;
    rd         = 1'b0;
    count_next = count;
    case (iol_pkg::op_t'(cmd_op))
      iol_pkg::OP_PUSH_BACK, iol_pkg::OP_PUSH_FRONT, iol_pkg::OP_INSERT_AT: begin
        if (iol_pkg::op_t'(cmd_op) == iol_pkg::OP_PUSH_BACK) begin
          op_pos = cnt_w;
        end else if (iol_pkg::op_t'(cmd_op) == iol_pkg::OP_PUSH_FRONT) begin
          op_pos = '0;
        end
        if (full) begin
          status = iol_pkg::ST_FULL;
        end else if (op_pos > cnt_w) begin
          status = iol_pkg::ST_RANGE;
        end else begin
          kind       = iol_pkg::CELL_INSERT;
          count_next = count + 1'b1;
        end
      end
      iol_pkg::OP_POP_FRONT, iol_pkg::OP_POP_BACK,
      iol_pkg::OP_READ_FIRST, iol_pkg::OP_READ_LAST: begin
        if (iol_pkg::op_t'(cmd_op) == iol_pkg::OP_POP_FRONT ||
            iol_pkg::op_t'(cmd_op) == iol_pkg::OP_READ_FIRST) begin
          op_pos = '0;
        end else begin
          op_pos = cnt_w - 1'b1;
        end
        if (empty) begin
          status = iol_pkg::ST_EMPTY;
        end else begin
          rd = 1'b1;
          if (iol_pkg::op_t'(cmd_op) == iol_pkg::OP_POP_FRONT ||
              iol_pkg::op_t'(cmd_op) == iol_pkg::OP_POP_BACK) begin
            kind       = iol_pkg::CELL_REMOVE;
            count_next = count - 1'b1;
          end
        end
      end
      iol_pkg::OP_REMOVE_AT, iol_pkg::OP_READ_AT, iol_pkg::OP_WRITE_AT: begin
        if (pos_w >= cnt_w) begin
          status = iol_pkg::ST_RANGE;
        end else begin
          rd = 1'b1;
          if (iol_pkg::op_t'(cmd_op) == iol_pkg::OP_REMOVE_AT) begin
            kind       = iol_pkg::CELL_REMOVE;
            count_next = count - 1'b1;
          end else if (iol_pkg::op_t'(cmd_op) == iol_pkg::OP_WRITE_AT) begin
            kind = iol_pkg::CELL_WRITE;
          end
        end
      end
      default: begin
      end
    endcase
  end

  assign ctl.kind = exec ? kind : iol_pkg::CELL_HOLD;
  assign ctl.pos  = op_pos;

  generate
    if (WORD_BITS >= 32) begin : g_wide
      assign word_in = WORD_BITS'(cmd_data);
      assign rd_word = tap_or[31:0];
    end else begin : g_narrow
      assign word_in = cmd_data[WORD_BITS-1:0];
      assign rd_word = {{(32 - WORD_BITS){tap_or[WORD_BITS-1]}}, tap_or};
    end
  endgenerate

  genvar gi;
  generate
    for (gi = 0; gi < CAPACITY; gi++) begin : g_cell
      logic [WORD_BITS-1:0] prev_w;
      logic [WORD_BITS-1:0] next_w;
      if (gi == 0) begin : g_first
        assign prev_w = word_in;
      end else begin : g_mid_prev
        assign prev_w = words[gi-1];
      end
      if (gi == CAPACITY - 1) begin : g_last
        assign next_w = words[gi];
      end else begin : g_mid_next
        assign next_w = words[gi+1];
      end
      iol_cell #(
        .IDX       (gi),
        .WORD_BITS (WORD_BITS)
      ) u_cell (
        .clk       (clk),
        .ctl       (ctl),
        .din       (word_in),
        .prev_word (prev_w),
        .next_word (next_w),
        .word      (words[gi]),
        .tap       (taps[gi])
      );
    end
  endgenerate

  always_comb begin
    tap_or = '0;
    for (int i = 0; i < CAPACITY; i++) begin
      tap_or = tap_or | taps[i];
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      cmd_valid <= 1'b0;
      out_valid <= 1'b0;
      count     <= '0;
    end else begin
      if (in_fire) begin
        cmd_valid <= 1'b1;
      end else if (exec) begin
        cmd_valid <= 1'b0;
      end
      if (exec) begin
        out_valid <= 1'b1;
        count     <= count_next;
      end else if (m_axis_tready) begin
        out_valid <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (in_fire) begin
      cmd_op   <= s_axis_tdata[3:0];
      cmd_pos  <= s_axis_tdata[10:4];
      cmd_data <= s_axis_tdata[42:11];
    end
    if (exec) begin
      out_data   <= rd ? rd_word : 32'd0;
      out_status <= status;
      out_count  <= 7'(count_next);
      out_empty  <= (count_next == '0);
    end
  end

  assign m_axis_tvalid = out_valid;
  assign m_axis_tdata  = {6'd0, out_empty, out_count, out_status, out_data};

  // checks
  assert property (@(posedge clk) disable iff (rst) count <= CAP_CNT)
    else $error("count above capacity");

  assert property (@(posedge clk) disable iff (rst)
    exec && status != iol_pkg::ST_OK |=> count == $past(count))
    else $error("failed request changed the count");

  assert property (@(posedge clk) disable iff (rst)
    cmd_valid && !exec |=> cmd_valid && $stable(cmd_op) && $stable(cmd_pos))
    else $error("pending request lost while result stalled");

  assert property (@(posedge clk) disable iff (rst)
    exec |=> out_valid && out_empty == (count == '0))
    else $error("empty flag disagrees with count");

endmodule

// ===== tb/tb_indexed_ordered_list_core.sv =====
// Testbench for indexed_ordered_list_core: directed and random list requests
// checked against an in-bench list predictor. Depends on iol_pkg and the core RTL.
module tb_indexed_ordered_list_core;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int CAPACITY    = 64;
  localparam int WORD_BITS   = 32;
  localparam int CYCLE_LIMIT = 200000;
  localparam int MAX_REPORTS = 10;

  localparam logic [3:0] OP_UNUSED_LO = 4'd10;
  localparam logic [3:0] OP_UNUSED_HI = 4'd15;

  typedef struct packed {
    logic [31:0]      data_out;
    iol_pkg::status_t status;
    logic [6:0]       count;
    logic             is_empty;
  } list_result_t;

  logic        clk = 1'b0;
  logic        rst = 1'b1;
  logic        s_axis_tvalid = 1'b0;
  logic        s_axis_tready;
  logic [47:0] s_axis_tdata = '0;   // opcode, position, data_in, zero pad
  logic        m_axis_tvalid;
  logic        m_axis_tready = 1'b0;
  logic [47:0] m_axis_tdata;        // data_out, status, count, is_empty, zero pad

  indexed_ordered_list_core #(
    .CAPACITY (CAPACITY),
    .WORD_BITS(WORD_BITS)
  ) uut (
    .clk          (clk),
    .rst          (rst),
    .s_axis_tvalid(s_axis_tvalid),
    .s_axis_tready(s_axis_tready),
    .s_axis_tdata (s_axis_tdata),
    .m_axis_tvalid(m_axis_tvalid),
    .m_axis_tready(m_axis_tready),
    .m_axis_tdata (m_axis_tdata)
  );

  always #10 clk = ~clk;

  // shadow copy of the list
  logic [31:0] shadow_words [CAPACITY];
  int unsigned shadow_count = 0;

  list_result_t expected_results [$];

  int src_idle_pct  = 16;
  int sink_idle_pct = 60;
  int err_count     = 0;
  int n_requests    = 0;
  int n_results     = 0;
  int n_full_seen   = 0;
  int n_empty_seen  = 0;
  int n_range_seen  = 0;
  int cycle_count   = 0;

  task automatic apply_list_op(input logic [3:0] op, input logic [6:0] pos,
                               input logic [31:0] word, output list_result_t res);
    int i;
    res.data_out = '0;
    res.status   = iol_pkg::ST_OK;
    case (op)
      iol_pkg::OP_PUSH_BACK, iol_pkg::OP_PUSH_FRONT, iol_pkg::OP_INSERT_AT: begin
        if (shadow_count >= CAPACITY) begin
          res.status = iol_pkg::ST_FULL;
        end else if (op == iol_pkg::OP_INSERT_AT && pos > shadow_count) begin
          res.status = iol_pkg::ST_RANGE;
        end else begin
          if (op == iol_pkg::OP_PUSH_BACK) pos = 7'(shadow_count);
          else if (op == iol_pkg::OP_PUSH_FRONT) pos = '0;
          for (i = shadow_count; i > pos; i--) shadow_words[i] = shadow_words[i-1];
          shadow_words[pos] = word;
          shadow_count++;
        end
      end
      iol_pkg::OP_POP_FRONT, iol_pkg::OP_POP_BACK,
      iol_pkg::OP_READ_FIRST, iol_pkg::OP_READ_LAST: begin
        if (shadow_count == 0) begin
          res.status = iol_pkg::ST_EMPTY;
        end else begin
          pos = (op == iol_pkg::OP_POP_FRONT || op == iol_pkg::OP_READ_FIRST) ?
                '0 : 7'(shadow_count - 1);
          res.data_out = shadow_words[pos];
          if (op == iol_pkg::OP_POP_FRONT || op == iol_pkg::OP_POP_BACK) begin
            for (i = pos; i + 1 < shadow_count; i++) shadow_words[i] = shadow_words[i+1];
            shadow_count--;
          end
        end
      end
      iol_pkg::OP_REMOVE_AT, iol_pkg::OP_READ_AT, iol_pkg::OP_WRITE_AT: begin
        if (pos >= shadow_count) begin
          res.status = iol_pkg::ST_RANGE;
        end else begin
          res.data_out = shadow_words[pos];
          if (op == iol_pkg::OP_WRITE_AT) begin
            shadow_words[pos] = word;
          end else if (op == iol_pkg::OP_REMOVE_AT) begin
            for (i = pos; i + 1 < shadow_count; i++) shadow_words[i] = shadow_words[i+1];
            shadow_count--;
          end
        end
      end
      default: ;
    endcase
    res.count    = shadow_count[6:0];
    res.is_empty = (shadow_count == 0);
  endtask

  task automatic send_request(input logic [3:0] op, input logic [6:0] pos,
                              input logic [31:0] word);
    list_result_t res;
    while ($urandom_range(99) < src_idle_pct) begin
      s_axis_tvalid <= 1'b0;
      @(posedge clk);
    end
    s_axis_tvalid <= 1'b1;
    s_axis_tdata  <= {5'b0, word, pos, op};
    @(posedge clk);
    while (!s_axis_tready) @(posedge clk);
    apply_list_op(op, pos, word, res);
    expected_results.push_back(res);
    n_requests++;
  endtask

  task automatic report_mismatch(input string what, input logic [31:0] want,
                                 input logic [31:0] got);
    if (err_count < MAX_REPORTS)
      $display("mismatch at result %0d: %s expected %h actual %h", n_results, what, want, got);
    err_count++;
  endtask

  always @(posedge clk) begin
    m_axis_tready <= ($urandom_range(99) >= sink_idle_pct);
  end

  list_result_t want;

  always @(posedge clk) begin
    if (!rst && m_axis_tvalid && m_axis_tready) begin
      if (expected_results.size() == 0) begin
        report_mismatch("unrequested result", '0, m_axis_tdata[31:0]);
      end else begin
        want = expected_results.pop_front();
        if (m_axis_tdata[31:0] !== want.data_out)
          report_mismatch("data_out", want.data_out, m_axis_tdata[31:0]);
        if (m_axis_tdata[33:32] !== want.status)
          report_mismatch("status", 32'(want.status), 32'(m_axis_tdata[33:32]));
        if (m_axis_tdata[40:34] !== want.count)
          report_mismatch("count", 32'(want.count), 32'(m_axis_tdata[40:34]));
        if (m_axis_tdata[41] !== want.is_empty)
          report_mismatch("is_empty", 32'(want.is_empty), 32'(m_axis_tdata[41]));
        case (want.status)
          iol_pkg::ST_FULL:  n_full_seen++;
          iol_pkg::ST_EMPTY: n_empty_seen++;
          iol_pkg::ST_RANGE: n_range_seen++;
          default: ;
        endcase
      end
      n_results++;
    end
  end

  always @(posedge clk) begin
    cycle_count++;
    if (cycle_count > CYCLE_LIMIT) begin
      $display("timeout after %0d cycles", cycle_count);
      $display("RESULT: ERROR");
      $finish;
    end
  end

  task automatic test_empty_list();
    send_request(iol_pkg::OP_POP_FRONT,  7'd0,  32'h0000_0001);
    send_request(iol_pkg::OP_POP_BACK,   7'd0,  32'h0000_0002);
    send_request(iol_pkg::OP_READ_FIRST, 7'd0,  32'h0000_0003);
    send_request(iol_pkg::OP_READ_LAST,  7'd64, 32'h0000_0004);
    send_request(iol_pkg::OP_REMOVE_AT,  7'd0,  32'h0000_0005);
    send_request(iol_pkg::OP_READ_AT,    7'd0,  32'h0000_0006);
    send_request(iol_pkg::OP_WRITE_AT,   7'd0,  32'h0000_0007);
    send_request(iol_pkg::OP_INSERT_AT,  7'd1,  32'h0000_0008);
  endtask

  task automatic test_basic_ops();
    send_request(iol_pkg::OP_PUSH_BACK,  7'd0,  32'h7FFF_FFFF);
    send_request(iol_pkg::OP_PUSH_FRONT, 7'd64, 32'h8000_0000);
    send_request(iol_pkg::OP_INSERT_AT,  7'd1,  32'hFFFF_FFFF);
    send_request(iol_pkg::OP_INSERT_AT,  7'd3,  32'h0000_0000);
    send_request(iol_pkg::OP_INSERT_AT,  7'd5,  32'h1111_1111);
    send_request(iol_pkg::OP_READ_FIRST, 7'd0,  32'h0);
    send_request(iol_pkg::OP_READ_LAST,  7'd0,  32'h0);
    send_request(iol_pkg::OP_READ_AT,    7'd2,  32'h0);
    send_request(iol_pkg::OP_WRITE_AT,   7'd0,  32'h1234_5678);
    send_request(iol_pkg::OP_REMOVE_AT,  7'd1,  32'h0);
    send_request(iol_pkg::OP_READ_AT,    7'd3,  32'h0);
    send_request(iol_pkg::OP_POP_FRONT,  7'd0,  32'h0);
    send_request(iol_pkg::OP_POP_BACK,   7'd0,  32'h0);
  endtask

  task automatic test_unused_opcodes();
    for (int k = int'(OP_UNUSED_LO); k <= int'(OP_UNUSED_HI); k++)
      send_request(4'(k), 7'($urandom_range(64)), $urandom());
  endtask

  task automatic test_full_list();
    while (shadow_count < CAPACITY) send_request(iol_pkg::OP_PUSH_BACK, 7'd0, $urandom());
    send_request(iol_pkg::OP_PUSH_BACK,  7'd0,  32'hDEAD_0001);
    send_request(iol_pkg::OP_PUSH_FRONT, 7'd0,  32'hDEAD_0002);
    send_request(iol_pkg::OP_INSERT_AT,  7'd64, 32'hDEAD_0003);
    send_request(iol_pkg::OP_READ_LAST,  7'd0,  32'h0);
    send_request(iol_pkg::OP_READ_AT,    7'd63, 32'h0);
    send_request(iol_pkg::OP_READ_AT,    7'd64, 32'h0);
    send_request(iol_pkg::OP_WRITE_AT,   7'd63, 32'hCAFE_F00D);
    send_request(iol_pkg::OP_REMOVE_AT,  7'd0,  32'h0);
    send_request(iol_pkg::OP_POP_BACK,   7'd0,  32'h0);
  endtask

  // each segment of 50 requests picks filling, draining or balanced traffic at random
  task automatic test_random_traffic(input int n_items, input int src_pct, input int sink_pct);
    int k;
    int mode;
    int r;
    int grow_pct;
    int shrink_pct;
    logic [3:0] op;
    logic [6:0] pos;
    logic [31:0] word;
    src_idle_pct  = src_pct;
    sink_idle_pct = sink_pct;
    mode = 0;
    for (k = 0; k < n_items; k++) begin
      if (k % 50 == 0) mode = $urandom_range(2);
      grow_pct   = (mode == 0) ? 70 : (mode == 1) ? 15 : 35;
      shrink_pct = (mode == 0) ? 15 : (mode == 1) ? 70 : 35;
      r = $urandom_range(99);
      if ($urandom_range(99) < 3) begin
        op = 4'($urandom_range(OP_UNUSED_HI, OP_UNUSED_LO));
      end else if (r < grow_pct) begin
        case ($urandom_range(2))
          0: op = iol_pkg::OP_PUSH_BACK;
          1: op = iol_pkg::OP_PUSH_FRONT;
          default: op = iol_pkg::OP_INSERT_AT;
        endcase
      end else if (r < grow_pct + shrink_pct) begin
        case ($urandom_range(2))
          0: op = iol_pkg::OP_POP_FRONT;
          1: op = iol_pkg::OP_POP_BACK;
          default: op = iol_pkg::OP_REMOVE_AT;
        endcase
      end else begin
        case ($urandom_range(3))
          0: op = iol_pkg::OP_READ_AT;
          1: op = iol_pkg::OP_READ_FIRST;
          2: op = iol_pkg::OP_READ_LAST;
          default: op = iol_pkg::OP_WRITE_AT;
        endcase
      end
      if (op == iol_pkg::OP_INSERT_AT && $urandom_range(9) != 0)
        pos = 7'($urandom_range(shadow_count));
      else if ((op == iol_pkg::OP_REMOVE_AT || op == iol_pkg::OP_READ_AT ||
                op == iol_pkg::OP_WRITE_AT)
               && shadow_count != 0 && $urandom_range(9) != 0)
        pos = 7'($urandom_range(shadow_count - 1));
      else
        pos = 7'($urandom_range(64));
      case ($urandom_range(9))
        0: word = 32'h8000_0000;
        1: word = 32'h7FFF_FFFF;
        2: word = 32'h0000_0000;
        3: word = 32'hFFFF_FFFF;
        default: word = $urandom();
      endcase
      send_request(op, pos, word);
    end
  endtask

  initial begin
    repeat (3) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);
    test_empty_list();
    test_basic_ops();
    test_unused_opcodes();
    test_full_list();
    test_random_traffic(585, 16, 60);
    test_random_traffic(585, 60, 16);
    test_random_traffic(585, 0, 0);
    s_axis_tvalid <= 1'b0;
    while (expected_results.size() != 0) @(posedge clk);
    repeat (8) @(posedge clk);
    $display("%0d requests sent, %0d results checked, %0d mismatches",
             n_requests, n_results, err_count);
    $display("status seen: full %0d, empty %0d, bad position %0d",
             n_full_seen, n_empty_seen, n_range_seen);
    if (err_count == 0) begin
      $display("RESULT: OK");
    end else begin
      $display("RESULT: ERROR");
    end
    $finish;
  end

endmodule
